// ===== rtl/core/sff_pkg.sv =====
// Shared constants and action codes for the synchronous FIFO with flags.
// No dependencies; used by synchronous_fifo_with_flags and sff_checker.
package sff_pkg;

  localparam int QUEUE_DEPTH  = 1024;
  localparam int WORD_BITS    = 64;
  localparam bit OUTPUT_STAGE = 1'b0;

  localparam int FIELD_BITS  = 64;
  localparam int ACTION_BITS = 3;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 2);

  localparam logic [ACTION_BITS-1:0] ACT_IDLE     = 3'd0;
  localparam logic [ACTION_BITS-1:0] ACT_PUSH     = 3'd1;
  localparam logic [ACTION_BITS-1:0] ACT_POP      = 3'd2;
  localparam logic [ACTION_BITS-1:0] ACT_PUSH_POP = 3'd3;
  localparam logic [ACTION_BITS-1:0] ACT_CLEAR    = 3'd4;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [OCC_W-1:0] occ_t;
  typedef logic [WORD_BITS-1:0] word_t;

endpackage

// ===== rtl/core/sff_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module sff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/synchronous_fifo_with_flags.sv =====
// An input transfer passes through update and write (S_IDLE), a single read of the new
// head (S_READ) and the output load (S_DONE); in_ready is low until the output load, so
// one item is in progress at a time; the load waits while a held result is not taken.
// Reset clears pointers, full and half flags, the output stage valid bit and handshake
// state; not the word store or result registers. Depends on sff_pkg and sff_ram.
module synchronous_fifo_with_flags (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sff_pkg::ACTION_BITS-1:0]    in_action,
  input  logic [sff_pkg::FIELD_BITS-1:0]     in_push_word,
  output logic                               out_vld,
  input  logic                               out_ready,
  output logic [sff_pkg::FIELD_BITS-1:0]     out_head_word,
  output logic                               out_is_empty,
  output logic                               out_is_full,
  output logic                               out_almost_full,
  output logic                               out_overflow_error,
  output logic                               out_underflow_error
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]     state_r, state_nxt;
  sff_pkg::ptr_t  wp_r, wp_nxt, rp_r, rp_nxt;
  logic           full_r, full_nxt;
  logic           half_r, half_nxt;
  logic           ov_r, ov_nxt;
  sff_pkg::word_t ow_r, ow_nxt;
  logic           ovf_r, ovf_nxt, unf_r, unf_nxt;

  logic                            out_vld_r, out_vld_nxt;
  logic [sff_pkg::FIELD_BITS-1:0]  head_r, head_nxt;
  logic                            empty_r, empty_nxt, fullo_r, fullo_nxt;
  logic                            afull_r, afull_nxt, oerr_r, oerr_nxt, uerr_r, uerr_nxt;

  sff_pkg::word_t ram_rdata;
  logic           ram_we, ram_re;

  logic           accept, push, pop, clr, store_empty, take_head, put_word;
  logic           ovf, unf, ok, rd_go, wr_go, load_out, emp;
  sff_pkg::occ_t  count, occ;
  sff_pkg::ptr_t  wp_adv, rp_adv;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == S_DONE) && (!out_vld_r || out_ready);

  always_comb begin
    push = (in_action == sff_pkg::ACT_PUSH) || (in_action == sff_pkg::ACT_PUSH_POP);
    pop  = (in_action == sff_pkg::ACT_POP) || (in_action == sff_pkg::ACT_PUSH_POP);
    clr  = (in_action == sff_pkg::ACT_CLEAR);

    if (full_r) begin
      count = sff_pkg::OCC_W'(sff_pkg::QUEUE_DEPTH);
    end else if (wp_r >= rp_r) begin
      count = sff_pkg::OCC_W'(wp_r) - sff_pkg::OCC_W'(rp_r);
    end else begin
      count = sff_pkg::OCC_W'(sff_pkg::QUEUE_DEPTH) - sff_pkg::OCC_W'(rp_r)
              + sff_pkg::OCC_W'(wp_r);
    end
    occ = count + sff_pkg::OCC_W'(sff_pkg::OUTPUT_STAGE && ov_r);
    store_empty = !full_r && (wp_r == rp_r);

    if (sff_pkg::OUTPUT_STAGE) begin
      take_head = (!ov_r || pop) && !store_empty;
      put_word  = push && (!full_r || take_head);
      ovf       = push && !put_word;
      unf       = pop && !ov_r;
    end else begin
      take_head = pop;
      put_word  = push;
      unf       = pop && store_empty;
      ovf       = push && full_r && !pop;
    end
    ok    = !ovf && !unf;
    rd_go = ok && take_head;
    wr_go = ok && put_word;

    wp_adv = (wp_r == sff_pkg::PTR_W'(sff_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    rp_adv = (rp_r == sff_pkg::PTR_W'(sff_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;

    state_nxt = state_r;
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    full_nxt  = full_r;
    half_nxt  = half_r;
    ov_nxt    = ov_r;
    ow_nxt    = ow_r;
    ovf_nxt   = ovf_r;
    unf_nxt   = unf_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    out_vld_nxt = out_vld_r && !out_ready;
    head_nxt    = head_r;
    empty_nxt   = empty_r;
    fullo_nxt   = fullo_r;
    afull_nxt   = afull_r;
    oerr_nxt    = oerr_r;
    uerr_nxt    = uerr_r;

    if (sff_pkg::OUTPUT_STAGE) begin
      emp = !ov_r;
    end else begin
      emp = store_empty;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ram_we   = wr_go;
          ovf_nxt  = ovf;
          unf_nxt  = unf;
          half_nxt = occ >= sff_pkg::OCC_W'(sff_pkg::QUEUE_DEPTH / 2);
          if (rd_go) begin
            rp_nxt = rp_adv;
          end
          if (wr_go) begin
            wp_nxt = wp_adv;
          end
          if (wr_go && !rd_go) begin
            full_nxt = (wp_adv == rp_r);
          end else if (rd_go && !wr_go) begin
            full_nxt = 1'b0;
          end
          if (sff_pkg::OUTPUT_STAGE && ok) begin
            if (rd_go) begin
              ov_nxt = 1'b1;
              ow_nxt = ram_rdata;
            end else if (pop) begin
              ov_nxt = 1'b0;
            end
          end
          if (clr) begin
            wp_nxt   = '0;
            rp_nxt   = '0;
            full_nxt = 1'b0;
            ov_nxt   = 1'b0;
          end
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          out_vld_nxt = 1'b1;
          empty_nxt   = emp;
          afull_nxt   = half_r;
          oerr_nxt    = ovf_r;
          uerr_nxt    = unf_r;
          if (sff_pkg::OUTPUT_STAGE) begin
            fullo_nxt = full_r && ov_r;
            head_nxt  = ov_r ? sff_pkg::FIELD_BITS'(ow_r) : '0;
          end else begin
            fullo_nxt = full_r;
            head_nxt  = emp ? '0 : sff_pkg::FIELD_BITS'(ram_rdata);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wp_r      <= '0;
      rp_r      <= '0;
      full_r    <= 1'b0;
      half_r    <= 1'b0;
      ov_r      <= 1'b0;
      ow_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wp_r      <= wp_nxt;
      rp_r      <= rp_nxt;
      full_r    <= full_nxt;
      half_r    <= half_nxt;
      ov_r      <= ov_nxt;
      ow_r      <= ow_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ovf_r   <= ovf_nxt;
    unf_r   <= unf_nxt;
    head_r  <= head_nxt;
    empty_r <= empty_nxt;
    fullo_r <= fullo_nxt;
    afull_r <= afull_nxt;
    oerr_r  <= oerr_nxt;
    uerr_r  <= uerr_nxt;
  end

  sff_ram #(
    .WIDTH(sff_pkg::WORD_BITS),
    .DEPTH(sff_pkg::QUEUE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(in_push_word[sff_pkg::WORD_BITS-1:0]),
    .re   (ram_re),
    .raddr(rp_r),
    .rdata(ram_rdata)
  );

  assign out_vld             = out_vld_r;
  assign out_head_word       = head_r;
  assign out_is_empty        = empty_r;
  assign out_is_full         = fullo_r;
  assign out_almost_full     = afull_r;
  assign out_overflow_error  = oerr_r;
  assign out_underflow_error = uerr_r;

endmodule

// ===== rtl/core/sff_checker.sv =====
// Port-level checks on the FIFO results and input handshake, bound to synchronous_fifo_with_flags.
// Depends on sff_pkg.
module sff_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_vld,
  input logic                           out_ready,
  input logic [sff_pkg::FIELD_BITS-1:0] out_head_word,
  input logic                           out_is_empty,
  input logic                           out_is_full,
  input logic                           out_overflow_error,
  input logic                           out_underflow_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_ready |=> out_vld && $stable(out_head_word))
    else $error("Result changed while its transfer was stalled.");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> !(out_is_empty && out_is_full))
    else $error("Queue reported both empty and full.");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_is_empty |-> out_head_word == '0)
    else $error("Empty queue shows a nonzero head word.");

  a_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> !(out_overflow_error && out_underflow_error))
    else $error("Overflow and underflow reported for the same item.");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("A second item was taken while one was in progress.");

endmodule

bind synchronous_fifo_with_flags sff_checker u_sff_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_vld            (out_vld),
  .out_ready          (out_ready),
  .out_head_word      (out_head_word),
  .out_is_empty       (out_is_empty),
  .out_is_full        (out_is_full),
  .out_overflow_error (out_overflow_error),
  .out_underflow_error(out_underflow_error)
);
